FILE: sv/assert_macros.svh
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every edge outside reset
`define ASSERT_ON(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/jsel_pkg.sv
`default_nettype none

package jsel_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int NUM_STAGES = 9;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_LIMITS_ON  = 3'd0,
    CFG_SOFT_POS_LOW   = 3'd1,
    CFG_SOFT_POS_HIGH  = 3'd2,
    CFG_POSITION_GAIN  = 3'd3,
    CFG_VELOCITY_GAIN  = 3'd4,
    CFG_VELOCITY_LIMIT = 3'd5,
    CFG_EFFORT_LIMIT   = 3'd6
  } cfg_reg_t;

endpackage

`default_nettype wire

FILE: sv/joint_soft_effort_limiter.sv
// Channel  | Direction | Word
// ---------+-----------+---------------------------------------------------
// in_      | input     | joint_position, joint_velocity, effort_request
// out_     | output    | limited_effort
// cfg_     | input     | cfg_index, cfg_data (write only, cfg_we)
//
// One word per cycle when not stalled; stages: diff, partial multiplies, product sum and
// shift/clamp for the velocity bounds, the same four for the effort bounds, final clamp.
// Synchronous active-low reset clears the valid bits and config registers, not the data.
// out_stall holds the output register; a stage moves when it is empty or the next one
// moves, so bubbles are squeezed out and in_stall rises only when the first stage is
// full and cannot move.
`default_nettype none

module joint_soft_effort_limiter #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic signed [VALUE_WIDTH-1:0] in_joint_position,
  input  wire logic signed [VALUE_WIDTH-1:0] in_joint_velocity,
  input  wire logic signed [VALUE_WIDTH-1:0] in_effort_request,

  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic signed [VALUE_WIDTH-1:0] out_limited_effort,

  input  wire logic                          cfg_we,
  input  wire jsel_pkg::cfg_idx_t            cfg_index,
  input  wire logic        [VALUE_WIDTH-1:0] cfg_data
);

  import jsel_pkg::*;

  `include "assert_macros.svh"

  localparam int W   = VALUE_WIDTH;
  localparam int GW  = W - 1;
  localparam int H   = GW / 2;
  localparam int GHW = GW - H;
  localparam int DW  = W + 1;
  localparam int LW  = DW + H + 1;
  localparam int HW  = DW + GHW + 1;
  localparam int PW  = 2 * W;

  // config
  logic                 pos_on_r;
  logic signed [W-1:0]  soft_low_r;
  logic signed [W-1:0]  soft_high_r;
  logic        [GW-1:0] pos_gain_r;
  logic        [GW-1:0] vel_gain_r;
  logic        [GW-1:0] vel_lim_r;
  logic        [GW-1:0] eff_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_on_r    <= 1'b0;
      soft_low_r  <= '0;
      soft_high_r <= '0;
      pos_gain_r  <= '0;
      vel_gain_r  <= '0;
      vel_lim_r   <= '0;
      eff_lim_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POS_LIMITS_ON:  pos_on_r    <= cfg_data[0];
        CFG_SOFT_POS_LOW:   soft_low_r  <= $signed(cfg_data);
        CFG_SOFT_POS_HIGH:  soft_high_r <= $signed(cfg_data);
        CFG_POSITION_GAIN:  pos_gain_r  <= cfg_data[GW-1:0];
        CFG_VELOCITY_GAIN:  vel_gain_r  <= cfg_data[GW-1:0];
        CFG_VELOCITY_LIMIT: vel_lim_r   <= cfg_data[GW-1:0];
        CFG_EFFORT_LIMIT:   eff_lim_r   <= cfg_data[GW-1:0];
        default: ;
      endcase
    end
  end

  // full product from two partial products
  function automatic logic signed [PW-1:0] pp_sum(input logic signed [LW-1:0] lo,
                                                  input logic signed [HW-1:0] hi);
    logic signed [PW-1:0] lo_x;
    logic signed [PW-1:0] hi_x;
    lo_x = PW'(lo);
    hi_x = PW'(hi);
    return lo_x + (hi_x <<< H);
  endfunction

  // clamp(-floor(prod / 2^F), +-lim)
  function automatic logic signed [W-1:0] sat_bound(input logic signed [PW-1:0] prod,
                                                    input logic [GW-1:0] lim);
    logic signed [PW-1:0] q;
    logic signed [PW-1:0] lim_x;
    logic signed [PW-1:0] res;
    q     = prod >>> FRAC_BITS;
    lim_x = $signed({{(PW-GW){1'b0}}, lim});
    if (q > lim_x) begin
      res = -lim_x;
    end else if (q < -lim_x) begin
      res = lim_x;
    end else begin
      res = -q;
    end
    return res[W-1:0];
  endfunction

  // stage flow control
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES-1:0] adv;

  always_comb begin
    adv[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt = vld_r;
    if (adv[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (adv[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld_r[NUM_STAGES-1];

  // s1: position errors
  logic signed [DW-1:0] s1_dlo_r, s1_dhi_r;
  logic signed [W-1:0]  s1_vel_r, s1_req_r;
  // s2: partial products
  logic signed [LW-1:0] s2_lo_l_r, s2_hi_l_r;
  logic signed [HW-1:0] s2_lo_h_r, s2_hi_h_r;
  logic signed [W-1:0]  s2_vel_r, s2_req_r;
  // s3: full products
  logic signed [PW-1:0] s3_plo_r, s3_phi_r;
  logic signed [W-1:0]  s3_vel_r, s3_req_r;
  // s4: velocity bounds
  logic signed [W-1:0]  s4_vmin_r, s4_vmax_r, s4_vel_r, s4_req_r;
  // s5: velocity errors
  logic signed [DW-1:0] s5_ea_r, s5_eb_r;
  logic signed [W-1:0]  s5_req_r;
  // s6: partial products
  logic signed [LW-1:0] s6_a_l_r, s6_b_l_r;
  logic signed [HW-1:0] s6_a_h_r, s6_b_h_r;
  logic signed [W-1:0]  s6_req_r;
  // s7: full products
  logic signed [PW-1:0] s7_pa_r, s7_pb_r;
  logic signed [W-1:0]  s7_req_r;
  // s8: effort bounds
  logic signed [W-1:0]  s8_emin_r, s8_emax_r, s8_req_r;
  // s9: output
  logic signed [W-1:0]  out_r;

  logic signed [H:0]   pg_lo, vg_lo;
  logic signed [GHW:0] pg_hi, vg_hi;

  assign pg_lo = $signed({1'b0, pos_gain_r[H-1:0]});
  assign pg_hi = $signed({1'b0, pos_gain_r[GW-1:H]});
  assign vg_lo = $signed({1'b0, vel_gain_r[H-1:0]});
  assign vg_hi = $signed({1'b0, vel_gain_r[GW-1:H]});

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_dlo_r <= DW'(in_joint_position) - DW'(soft_low_r);
      s1_dhi_r <= DW'(in_joint_position) - DW'(soft_high_r);
      s1_vel_r <= in_joint_velocity;
      s1_req_r <= in_effort_request;
    end
    if (adv[1]) begin
      s2_lo_l_r <= s1_dlo_r * pg_lo;
      s2_lo_h_r <= s1_dlo_r * pg_hi;
      s2_hi_l_r <= s1_dhi_r * pg_lo;
      s2_hi_h_r <= s1_dhi_r * pg_hi;
      s2_vel_r  <= s1_vel_r;
      s2_req_r  <= s1_req_r;
    end
    if (adv[2]) begin
      s3_plo_r <= pp_sum(s2_lo_l_r, s2_lo_h_r);
      s3_phi_r <= pp_sum(s2_hi_l_r, s2_hi_h_r);
      s3_vel_r <= s2_vel_r;
      s3_req_r <= s2_req_r;
    end
    if (adv[3]) begin
      if (pos_on_r) begin
        s4_vmin_r <= sat_bound(s3_plo_r, vel_lim_r);
        s4_vmax_r <= sat_bound(s3_phi_r, vel_lim_r);
      end else begin
        s4_vmin_r <= -$signed({1'b0, vel_lim_r});
        s4_vmax_r <= $signed({1'b0, vel_lim_r});
      end
      s4_vel_r <= s3_vel_r;
      s4_req_r <= s3_req_r;
    end
    if (adv[4]) begin
      s5_ea_r  <= DW'(s4_vel_r) - DW'(s4_vmin_r);
      s5_eb_r  <= DW'(s4_vel_r) - DW'(s4_vmax_r);
      s5_req_r <= s4_req_r;
    end
    if (adv[5]) begin
      s6_a_l_r <= s5_ea_r * vg_lo;
      s6_a_h_r <= s5_ea_r * vg_hi;
      s6_b_l_r <= s5_eb_r * vg_lo;
      s6_b_h_r <= s5_eb_r * vg_hi;
      s6_req_r <= s5_req_r;
    end
    if (adv[6]) begin
      s7_pa_r  <= pp_sum(s6_a_l_r, s6_a_h_r);
      s7_pb_r  <= pp_sum(s6_b_l_r, s6_b_h_r);
      s7_req_r <= s6_req_r;
    end
    if (adv[7]) begin
      s8_emin_r <= sat_bound(s7_pa_r, eff_lim_r);
      s8_emax_r <= sat_bound(s7_pb_r, eff_lim_r);
      s8_req_r  <= s7_req_r;
    end
    if (adv[8]) begin
      // lower bound checked first; when the bounds cross, it wins only for requests below it
      if (s8_req_r < s8_emin_r) begin
        out_r <= s8_emin_r;
      end else if (s8_req_r > s8_emax_r) begin
        out_r <= s8_emax_r;
      end else begin
        out_r <= s8_req_r;
      end
    end
  end

  assign out_limited_effort = out_r;

  `ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_valid, "output valid right after reset")
  `ASSERT_ON(a_stall_full, clk, rst_n, in_stall |-> vld_r[0], "input stalled with first stage empty")
  `ASSERT_ON(a_accept_fills, clk, rst_n, (in_valid && !in_stall) |=> vld_r[0], "accepted word lost at first stage")

endmodule

`default_nettype wire

FILE: verif/tb_joint_soft_effort_limiter.sv
`timescale 1ns / 1ps

module tb_joint_soft_effort_limiter;
  import jsel_pkg::*;

  localparam int VW = 32;
  localparam int FRAC_BITS = 16;
  localparam int LATENCY = NUM_STAGES;
  localparam cfg_idx_t CFG_IDX_UNUSED = 3'd7;

  typedef struct packed {
    logic [VW-1:0] pos;
    logic [VW-1:0] vel;
    logic [VW-1:0] req;
  } joint_sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  joint_sample_t cur_word = '0;

  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VW-1:0] out_limited_effort;

  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = '0;
  logic [VW-1:0] cfg_data = '0;

  // shadow copy of the limiter registers
  logic limits_on = 1'b0;
  logic signed [VW-1:0] soft_low = '0;
  logic signed [VW-1:0] soft_high = '0;
  logic [VW-2:0] pos_gain = '0;
  logic [VW-2:0] vel_gain = '0;
  logic [VW-2:0] vel_lim = '0;
  logic [VW-2:0] eff_lim = '0;

  joint_sample_t pending_words[$];
  logic [VW-1:0] expected_efforts[$];
  logic [VW-1:0] effort_want;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit hold_go = 1'b0;
  logic stall_hold = 1'b0;
  int errors = 0;

  always #5 clk = ~clk;

  joint_soft_effort_limiter #(
    .VALUE_WIDTH(VW),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_joint_position (cur_word.pos),
    .in_joint_velocity (cur_word.vel),
    .in_effort_request (cur_word.req),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_limited_effort(out_limited_effort),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // -gain * diff, floor after the fraction shift, clamped to +-lim
  function automatic logic signed [95:0] gain_bound(logic signed [95:0] diff,
                                                    logic [VW-2:0] gain,
                                                    logic [VW-2:0] lim);
    logic signed [95:0] g;
    logic signed [95:0] l;
    logic signed [95:0] q;
    g = gain;
    l = lim;
    q = -((diff * g) >>> FRAC_BITS);
    if (q < -l) return -l;
    if (q > l) return l;
    return q;
  endfunction

  function automatic logic [VW-1:0] soft_limit_effort(joint_sample_t s);
    logic signed [95:0] pos;
    logic signed [95:0] vel;
    logic signed [95:0] req;
    logic signed [95:0] vl;
    logic signed [95:0] vmin;
    logic signed [95:0] vmax;
    logic signed [95:0] emin;
    logic signed [95:0] emax;
    logic signed [95:0] r;
    pos = $signed(s.pos);
    vel = $signed(s.vel);
    req = $signed(s.req);
    vl = vel_lim;
    if (limits_on) begin
      vmin = gain_bound(pos - soft_low, pos_gain, vel_lim);
      vmax = gain_bound(pos - soft_high, pos_gain, vel_lim);
    end else begin
      vmin = -vl;
      vmax = vl;
    end
    emin = gain_bound(vel - vmin, vel_gain, eff_lim);
    emax = gain_bound(vel - vmax, vel_gain, eff_lim);
    if (req < emin) r = emin;
    else if (req > emax) r = emax;
    else r = req;
    return r[VW-1:0];
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_efforts.push_back(soft_limit_effort(cur_word));
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_word <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_efforts.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual %h", $time,
                   out_limited_effort);
        end else begin
          effort_want = expected_efforts.pop_front();
          if (effort_want !== out_limited_effort) begin
            errors++;
            $display("%0t: limited_effort mismatch, expected %h, actual %h", $time,
                     effort_want, out_limited_effort);
          end
        end
      end
      out_stall <= stall_hold || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // long receiver hold-off so the pipe fills and stalls its input
  initial begin
    wait (hold_go);
    @(posedge clk);
    stall_hold <= 1'b1;
    repeat (300) @(posedge clk);
    stall_hold <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL joint_soft_effort_limiter");
    $finish;
  end

  task automatic write_reg(cfg_idx_t idx, logic [VW-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_POS_LIMITS_ON:  limits_on = data[0];
      CFG_SOFT_POS_LOW:   soft_low = data;
      CFG_SOFT_POS_HIGH:  soft_high = data;
      CFG_POSITION_GAIN:  pos_gain = data[VW-2:0];
      CFG_VELOCITY_GAIN:  vel_gain = data[VW-2:0];
      CFG_VELOCITY_LIMIT: vel_lim = data[VW-2:0];
      CFG_EFFORT_LIMIT:   eff_lim = data[VW-2:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_limits(logic [VW-1:0] on, logic [VW-1:0] lo, logic [VW-1:0] hi,
                              logic [VW-1:0] pg, logic [VW-1:0] vg, logic [VW-1:0] vlim,
                              logic [VW-1:0] elim);
    write_reg(CFG_POS_LIMITS_ON, on);
    write_reg(CFG_SOFT_POS_LOW, lo);
    write_reg(CFG_SOFT_POS_HIGH, hi);
    write_reg(CFG_POSITION_GAIN, pg);
    write_reg(CFG_VELOCITY_GAIN, vg);
    write_reg(CFG_VELOCITY_LIMIT, vlim);
    write_reg(CFG_EFFORT_LIMIT, elim);
  endtask

  function automatic logic [VW-1:0] rand_value(logic [VW-1:0] center, int unsigned span);
    case ($urandom_range(7))
      0: return $urandom;
      1: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          default: return 32'h0;
        endcase
      end
      default: return center + $urandom_range(0, 2 * span) - span;
    endcase
  endfunction

  task automatic push_word(logic [VW-1:0] pos, logic [VW-1:0] vel, logic [VW-1:0] req);
    pending_words.push_back('{pos: pos, vel: vel, req: req});
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || in_valid || expected_efforts.size() != 0)
      @(negedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  task automatic run_random(int n, int unsigned send_pct, int unsigned recv_pct);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n) begin
      push_word(rand_value($urandom_range(1) ? soft_low : soft_high, 32'h4_0000),
                rand_value(32'h0, 32'h3_0000),
                rand_value(32'h0, 32'h10_0000));
    end
    drain();
  endtask

  int unsigned send_mode[4] = '{0, 69, 0, 36};
  int unsigned recv_mode[4] = '{0, 0, 69, 36};
  logic [VW-1:0] lo_pick;

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: zero limits force a zero effort
    @(negedge clk);
    push_word(32'h0, 32'h0, 32'h0);
    push_word(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    push_word(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    drain();

    write_reg(CFG_IDX_UNUSED, 32'hffff_ffff);

    // low -1.0, high 1.0, gains 2.0 and 3.0, vel limit 1.5, effort limit 10.0
    apply_limits(32'h1, 32'hffff_0000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                 32'h0001_8000, 32'h000a_0000);
    @(negedge clk);
    push_word(32'h0, 32'h0, 32'h0);
    push_word(32'h0, 32'h0, 32'h0014_0000);
    push_word(32'h0, 32'h0, 32'hffec_0000);
    push_word(32'hfffe_0000, 32'h0, 32'h0);
    push_word(32'h0002_0000, 32'h0, 32'h0);
    push_word(32'h0001_0000, 32'h0000_8000, 32'h0005_0000);
    push_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    push_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_word(32'h7fff_ffff, 32'h8000_0000, 32'h0);
    push_word(32'h8000_0000, 32'h7fff_ffff, 32'h0);
    push_word(32'h0, 32'h0000_0001, 32'hffff_ffff);
    push_word(32'h0000_8000, 32'hffff_8001, 32'h0000_0001);
    drain();

    // crossed soft limits
    apply_limits(32'h1, 32'h0001_0000, 32'hffff_0000, 32'h0002_0000, 32'h0003_0000,
                 32'h0001_8000, 32'h000a_0000);
    @(negedge clk);
    push_word(32'h0, 32'h0, 32'h0);
    push_word(32'h0, 32'h0, 32'h7fff_ffff);
    push_word(32'h0, 32'h0, 32'h8000_0000);
    push_word(32'h0, 32'h0001_0000, 32'h0001_0000);
    push_word(32'h0002_0000, 32'hfffe_0000, 32'h0);
    drain();

    // widest settings, upper data bits set on the narrow registers
    apply_limits(32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    @(negedge clk);
    push_word(32'h0, 32'h0, 32'h0);
    push_word(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    push_word(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    drain();

    // continuous joint, random items
    apply_limits(32'h2, 32'hffff_0000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                 32'h0001_8000, 32'h000a_0000);
    @(negedge clk);
    hold_go = 1'b1;
    run_random(150, 0, 0);

    for (int k = 0; k < 8; k++) begin
      lo_pick = rand_value(32'h0, 32'h4_0000);
      apply_limits($urandom, lo_pick, rand_value(lo_pick + 32'h2_0000, 32'h3_0000),
                   rand_value(32'h2_0000, 32'h2_0000), rand_value(32'h2_0000, 32'h2_0000),
                   rand_value(32'h2_0000, 32'h2_0000), rand_value(32'h8_0000, 32'h8_0000));
      run_random(240, send_mode[k % 4], recv_mode[k % 4]);
    end

    if (errors == 0) begin
      $display("PASS joint_soft_effort_limiter");
    end else begin
      $display("FAIL joint_soft_effort_limiter");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/jsel_pkg.sv
sv/joint_soft_effort_limiter.sv
verif/tb_joint_soft_effort_limiter.sv
